// ----- rtl/integer_field_formatter_assert.svh -----
// Assertion helpers shared by the formatter RTL.
// Both expect clk and arst_n in scope at the point of use.
`ifndef INTEGER_FIELD_FORMATTER_ASSERT_SVH
`define INTEGER_FIELD_FORMATTER_ASSERT_SVH
`ifndef SYNTHESIS
`define IFF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("integer_field_formatter: same-cycle check failed");
`define IFF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("integer_field_formatter: next-cycle check failed");
`else
`define IFF_ASSERT_IMP(lbl, ante, cons)
`define IFF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/iff_pkg.sv -----
package iff_pkg;

	localparam int DIGITS = 10;
	localparam int NDW    = $clog2(DIGITS + 1);
	localparam int IW     = $clog2(DIGITS);
	localparam int STEPS  = 13;
	localparam int SW     = $clog2(STEPS);

	typedef logic [SW-1:0] step_t;

	localparam step_t ST_IDLE = SW'(0);
	localparam step_t ST_MUL  = SW'(1);
	localparam step_t ST_DIG  = SW'(2);
	localparam step_t ST_PAD  = SW'(3);
	localparam step_t ST_LSP  = SW'(4);
	localparam step_t ST_SIGN = SW'(5);
	localparam step_t ST_ZERO = SW'(6);
	localparam step_t ST_DIGS = SW'(7);
	localparam step_t ST_TSP  = SW'(8);
	localparam step_t ST_PFX0 = SW'(9);
	localparam step_t ST_PFXX = SW'(10);
	localparam step_t ST_CHR  = SW'(11);
	localparam step_t ST_PCT  = SW'(12);

	localparam logic [2:0] MODE_SDEC    = 3'd0;
	localparam logic [2:0] MODE_UDEC    = 3'd1;
	localparam logic [2:0] MODE_HEXL    = 3'd2;
	localparam logic [2:0] MODE_HEXU    = 3'd3;
	localparam logic [2:0] MODE_PTR     = 3'd4;
	localparam logic [2:0] MODE_CHAR    = 3'd5;
	localparam logic [2:0] MODE_PCT     = 3'd6;
	localparam logic [2:0] MODE_PCT_ALT = 3'd7;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_LA    = 8'h61;

	// floor(x / 10) == (x * RECIP10) >> DEC_SHIFT for every 32-bit x
	localparam logic [31:0] RECIP10   = 32'hCCCC_CCCD;
	localparam int          DEC_SHIFT = 35;

	typedef enum logic [2:0] {OP_IDLE, OP_MUL, OP_DIG, OP_PAD, OP_EMIT} op_t;
	typedef enum logic [2:0] {
		SRC_SPACE, SRC_MINUS, SRC_ZERO, SRC_X, SRC_DIGIT, SRC_VALUE, SRC_PCT
	} src_t;
	typedef enum logic [2:0] {G_ALWAYS, G_LEAD, G_NEG, G_ZPAD, G_LEFT} guard_t;
	typedef enum logic [1:0] {R_ONCE, R_PAD, R_DIG} rep_t;
	typedef enum logic [1:0] {L_NEVER, L_ALWAYS, L_DIG, L_PAD} lst_t;

	typedef struct packed {
		op_t    op;
		src_t   src;
		guard_t guard;
		rep_t   rep;
		lst_t   lst;
		step_t  nxt;
		step_t  brn;
	} ucode_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic dig;
		logic pad;
		logic dec_pad;
		logic dec_dig;
	} dp_ctl_t;

	typedef struct packed {
		logic       quot_nz;
		logic       pad_nz;
		logic       pad_one;
		logic       nd_one;
		logic       nd_zero;
		logic       neg;
		logic       zpad;
		logic       left;
		logic [7:0] dig_char;
		logic [7:0] val_byte;
	} dp_stat_t;

	function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		base = upper ? CH_UA : CH_LA;
		if (d < 4'd10)
			return CH_ZERO + {4'b0000, d};
		return base + {4'b0000, d} - 8'd10;
	endfunction

endpackage

// ----- rtl/integer_field_formatter.sv -----
// Integer field formatter: turns one conversion request into ASCII characters.
// Input channel (in_valid/in_ready) takes a request word: mode, value, field_width,
// zero_fill, left_justify. Output channel (out_valid/out_ready) gives one character
// per word in char_out, with last set on the final character of the request.
// A request is taken only while the sequencer sits at its idle step; the final
// character of the previous request may still be waiting in the output register.
// Steps: decimal and hex digits come from a loop of a reciprocal multiply step and
// a digit step, then a padding step sizes the padding, then the emit steps give
// one character per cycle while the receiver takes them; a padding or sign step
// that does not apply is skipped in a step of its own. Character and percent
// modes go straight to their single emit step.
// Reset clears the step counter and the output valid; no clearing pass is needed.
// When out_ready is low with a character pending, it holds and the sequencer stalls
// at its current emit step; conversion steps before it keep running.
`include "integer_field_formatter_assert.svh"

module integer_field_formatter #(
	parameter int WIDTH_LIMIT = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [31:0] value,
	input  logic [5:0]  field_width,
	input  logic        zero_fill,
	input  logic        left_justify,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  char_out,
	output logic        last
);
	import iff_pkg::*;

	step_t    step_q;
	step_t    step_d;
	step_t    disp;
	ucode_t   uc;
	dp_ctl_t  ctl;
	dp_stat_t stat;
	logic     out_valid_q;
	logic [7:0] char_q;
	logic     last_q;
	logic     out_free;
	logic     guard_ok;
	logic     active;
	logic     done;
	logic     emit;
	logic [7:0] char_d;
	logic     last_d;

	iff_ucode_rom u_rom (
		.step (step_q),
		.mode (mode),
		.uc   (uc),
		.disp (disp)
	);

	iff_datapath #(
		.WIDTH_LIMIT (WIDTH_LIMIT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.mode         (mode),
		.value        (value),
		.field_width  (field_width),
		.zero_fill    (zero_fill),
		.left_justify (left_justify),
		.stat         (stat)
	);

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (uc.op == OP_IDLE);

	always_comb begin
		case (uc.guard)
			G_ALWAYS: guard_ok = 1'b1;
			G_LEAD:   guard_ok = !stat.left && !stat.zpad;
			G_NEG:    guard_ok = stat.neg;
			G_ZPAD:   guard_ok = stat.zpad;
			G_LEFT:   guard_ok = stat.left;
			default:  guard_ok = 1'b0;
		endcase
	end

	assign active = guard_ok && !((uc.rep == R_PAD) && !stat.pad_nz);

	always_comb begin
		case (uc.rep)
			R_ONCE:  done = 1'b1;
			R_PAD:   done = stat.pad_one;
			R_DIG:   done = stat.nd_one;
			default: done = 1'b1;
		endcase
	end

	always_comb begin
		case (uc.src)
			SRC_SPACE: char_d = CH_SPACE;
			SRC_MINUS: char_d = CH_MINUS;
			SRC_ZERO:  char_d = CH_ZERO;
			SRC_X:     char_d = CH_X;
			SRC_DIGIT: char_d = stat.dig_char;
			SRC_VALUE: char_d = stat.val_byte;
			SRC_PCT:   char_d = CH_PCT;
			default:   char_d = CH_PCT;
		endcase
	end

	always_comb begin
		case (uc.lst)
			L_NEVER:  last_d = 1'b0;
			L_ALWAYS: last_d = 1'b1;
			L_DIG:    last_d = stat.nd_one && !(stat.left && stat.pad_nz);
			L_PAD:    last_d = stat.pad_one;
			default:  last_d = 1'b0;
		endcase
	end

	always_comb begin
		step_d = step_q;
		ctl    = '0;
		emit   = 1'b0;
		case (uc.op)
			OP_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					step_d   = disp;
				end
			end
			OP_MUL: begin
				ctl.mul = 1'b1;
				step_d  = uc.nxt;
			end
			OP_DIG: begin
				ctl.dig = 1'b1;
				step_d  = stat.quot_nz ? uc.brn : uc.nxt;
			end
			OP_PAD: begin
				ctl.pad = 1'b1;
				step_d  = uc.nxt;
			end
			OP_EMIT: begin
				// skip a step that does not apply; hold while the output is full
				if (!active) begin
					step_d = uc.nxt;
				end else if (out_free) begin
					emit        = 1'b1;
					ctl.dec_pad = (uc.rep == R_PAD);
					ctl.dec_dig = (uc.rep == R_DIG);
					if (done)
						step_d = uc.nxt;
				end
			end
			default: step_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			step_q <= step_d;
			if (emit) begin
				out_valid_q <= 1'b1;
				char_q      <= char_d;
				last_q      <= last_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign char_out  = char_q;
	assign last      = last_q;

	`IFF_ASSERT_NXT(a_leave_idle, in_valid && in_ready, step_q != ST_IDLE)
	`IFF_ASSERT_NXT(a_last_ends, emit && last_d, (step_q == ST_IDLE) || (step_q == ST_TSP))
	`IFF_ASSERT_IMP(a_digit_avail, emit && (uc.src == SRC_DIGIT), !stat.nd_zero)

endmodule

// ----- rtl/iff_ucode_rom.sv -----
module iff_ucode_rom (
	input  iff_pkg::step_t  step,
	input  logic [2:0]      mode,
	output iff_pkg::ucode_t uc,
	output iff_pkg::step_t  disp
);
	import iff_pkg::*;

	always_comb begin
		case (step)
			ST_IDLE: uc = '{OP_IDLE, SRC_SPACE, G_ALWAYS, R_ONCE, L_NEVER, ST_IDLE, ST_IDLE};
			ST_MUL:  uc = '{OP_MUL,  SRC_SPACE, G_ALWAYS, R_ONCE, L_NEVER, ST_DIG,  ST_IDLE};
			// loop back for the next digit while the quotient is nonzero
			ST_DIG:  uc = '{OP_DIG,  SRC_SPACE, G_ALWAYS, R_ONCE, L_NEVER, ST_PAD,  ST_MUL};
			ST_PAD:  uc = '{OP_PAD,  SRC_SPACE, G_ALWAYS, R_ONCE, L_NEVER, ST_LSP,  ST_IDLE};
			ST_LSP:  uc = '{OP_EMIT, SRC_SPACE, G_LEAD,   R_PAD,  L_NEVER, ST_SIGN, ST_IDLE};
			ST_SIGN: uc = '{OP_EMIT, SRC_MINUS, G_NEG,    R_ONCE, L_NEVER, ST_ZERO, ST_IDLE};
			ST_ZERO: uc = '{OP_EMIT, SRC_ZERO,  G_ZPAD,   R_PAD,  L_NEVER, ST_DIGS, ST_IDLE};
			ST_DIGS: uc = '{OP_EMIT, SRC_DIGIT, G_ALWAYS, R_DIG,  L_DIG,   ST_TSP,  ST_IDLE};
			ST_TSP:  uc = '{OP_EMIT, SRC_SPACE, G_LEFT,   R_PAD,  L_PAD,   ST_IDLE, ST_IDLE};
			ST_PFX0: uc = '{OP_EMIT, SRC_ZERO,  G_ALWAYS, R_ONCE, L_NEVER, ST_PFXX, ST_IDLE};
			ST_PFXX: uc = '{OP_EMIT, SRC_X,     G_ALWAYS, R_ONCE, L_NEVER, ST_MUL,  ST_IDLE};
			ST_CHR:  uc = '{OP_EMIT, SRC_VALUE, G_ALWAYS, R_ONCE, L_ALWAYS, ST_IDLE, ST_IDLE};
			ST_PCT:  uc = '{OP_EMIT, SRC_PCT,   G_ALWAYS, R_ONCE, L_ALWAYS, ST_IDLE, ST_IDLE};
			default: uc = '{OP_IDLE, SRC_SPACE, G_ALWAYS, R_ONCE, L_NEVER, ST_IDLE, ST_IDLE};
		endcase
	end

	// entry point of the program for each mode
	always_comb begin
		case (mode)
			MODE_PTR:               disp = ST_PFX0;
			MODE_CHAR:              disp = ST_CHR;
			MODE_PCT, MODE_PCT_ALT: disp = ST_PCT;
			default:                disp = ST_MUL;
		endcase
	end

endmodule

// ----- rtl/iff_datapath.sv -----
`include "integer_field_formatter_assert.svh"

module iff_datapath #(
	parameter int WIDTH_LIMIT = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  iff_pkg::dp_ctl_t  ctl,
	input  logic [2:0]        mode,
	input  logic [31:0]       value,
	input  logic [5:0]        field_width,
	input  logic              zero_fill,
	input  logic              left_justify,
	output iff_pkg::dp_stat_t stat
);
	import iff_pkg::*;

	localparam int PW = $clog2(WIDTH_LIMIT + 1);

	logic [31:0]    mag_q;
	logic [63:0]    prod_q;
	logic [3:0]     dig_q [DIGITS];
	logic [NDW-1:0] nd_q;
	logic [PW-1:0]  pad_q;
	logic [PW-1:0]  width_q;
	logic           neg_q;
	logic           zpad_q;
	logic           left_q;
	logic           hex_q;
	logic           upper_q;
	logic [7:0]     val_q;

	logic           num_mode;
	logic [5:0]     w_sat;
	logic [28:0]    quot_dec;
	logic [31:0]    quot;
	logic [31:0]    q10;
	logic [31:0]    rem_full;
	logic [3:0]     digit;
	logic [NDW-1:0] nd_dec;
	logic [6:0]     w7;
	logic [6:0]     n7;

	assign num_mode = (mode == MODE_SDEC) || (mode == MODE_UDEC) ||
	                  (mode == MODE_HEXL) || (mode == MODE_HEXU);
	assign w_sat    = (field_width > 6'(WIDTH_LIMIT)) ? 6'(WIDTH_LIMIT) : field_width;

	assign quot_dec = prod_q[DEC_SHIFT +: 29];
	assign quot     = hex_q ? {4'b0000, mag_q[31:4]} : {3'b000, quot_dec};
	assign q10      = {quot_dec, 3'b000} + {2'b00, quot_dec, 1'b0};
	assign rem_full = mag_q - q10;
	assign digit    = hex_q ? mag_q[3:0] : rem_full[3:0];
	assign nd_dec   = nd_q - NDW'(1);
	assign w7       = 7'(width_q);
	assign n7       = 7'(nd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_q  <= '0;
			pad_q <= '0;
		end else begin
			if (ctl.load) begin
				nd_q  <= '0;
				pad_q <= '0;
			end
			if (ctl.dig)
				nd_q <= nd_q + NDW'(1);
			if (ctl.dec_dig)
				nd_q <= nd_dec;
			if (ctl.pad)
				pad_q <= (w7 > n7) ? PW'(w7 - n7) : '0;
			if (ctl.dec_pad)
				pad_q <= pad_q - PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			neg_q   <= (mode == MODE_SDEC) && value[31];
			mag_q   <= ((mode == MODE_SDEC) && value[31]) ? (32'd0 - value) : value;
			width_q <= num_mode ? PW'(w_sat) : '0;
			zpad_q  <= num_mode && zero_fill && !left_justify;
			left_q  <= num_mode && left_justify;
			hex_q   <= (mode == MODE_HEXL) || (mode == MODE_HEXU) || (mode == MODE_PTR);
			upper_q <= (mode == MODE_HEXU);
			val_q   <= value[7:0];
		end
		if (ctl.mul)
			prod_q <= mag_q * RECIP10;
		if (ctl.dig) begin
			dig_q[nd_q[IW-1:0]] <= digit;
			mag_q               <= quot;
		end
	end

	assign stat.quot_nz  = (quot != 32'd0);
	assign stat.pad_nz   = (pad_q != '0);
	assign stat.pad_one  = (pad_q == PW'(1));
	assign stat.nd_one   = (nd_q == NDW'(1));
	assign stat.nd_zero  = (nd_q == '0);
	assign stat.neg      = neg_q;
	assign stat.zpad     = zpad_q;
	assign stat.left     = left_q;
	assign stat.dig_char = digit_ascii(dig_q[nd_dec[IW-1:0]], upper_q);
	assign stat.val_byte = val_q;

	`IFF_ASSERT_NXT(a_mul_then_dig, ctl.mul, ctl.dig)
	`IFF_ASSERT_IMP(a_nd_bound, 1'b1, nd_q <= NDW'(DIGITS))
	`IFF_ASSERT_IMP(a_pad_bound, pad_q != '0, pad_q <= width_q)

endmodule

// ----- sim/integer_field_formatter_tb.sv -----
`timescale 1ns / 1ps

module integer_field_formatter_tb;
	import iff_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_ITEMS = 128;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} char_word_t;

	class conversion_checker;
		char_word_t awaited[$];
		int mismatches;

		function new();
			mismatches = 0;
		endfunction

		function void add_digits(ref logic [7:0] txt[$], input logic [31:0] mag,
			input int unsigned radix, input bit upper);
			logic [7:0] rev[$];
			logic [31:0] d;
			do begin
				d = mag % radix;
				if (d < 10)
					rev.push_front(CH_ZERO + d[7:0]);
				else
					rev.push_front((upper ? CH_UA : CH_LA) + d[7:0] - 8'd10);
				mag = mag / radix;
			end while (mag != 0);
			foreach (rev[i])
				txt.push_back(rev[i]);
		endfunction

		// expand one accepted request into the characters it must produce
		function void note_request(logic [2:0] md, logic [31:0] val, logic [5:0] fw,
			logic zp, logic lj);
			logic [7:0] txt[$];
			logic [7:0] digs[$];
			logic [31:0] mag;
			int unsigned radix;
			int unsigned pad;
			bit neg;
			bit upper;
			bit zeros;
			char_word_t w;
			neg = 0;
			upper = 0;
			mag = val;
			radix = 10;
			zeros = zp && !lj;
			case (md)
				MODE_CHAR: txt.push_back(val[7:0]);
				MODE_PCT, MODE_PCT_ALT: txt.push_back(CH_PCT);
				MODE_PTR: begin
					txt.push_back(CH_ZERO);
					txt.push_back(CH_X);
					add_digits(txt, val, 16, 0);
				end
				default: begin
					if (md == MODE_SDEC) begin
						neg = val[31];
						if (neg)
							mag = 32'd0 - val;
					end else if (md != MODE_UDEC) begin
						radix = 16;
						upper = (md == MODE_HEXU);
					end
					add_digits(digs, mag, radix, upper);
					pad = (fw > digs.size()) ? fw - digs.size() : 0;
					if (!lj && !zeros)
						repeat (pad) txt.push_back(CH_SPACE);
					if (neg)
						txt.push_back(CH_MINUS);
					if (zeros)
						repeat (pad) txt.push_back(CH_ZERO);
					foreach (digs[i])
						txt.push_back(digs[i]);
					if (lj)
						repeat (pad) txt.push_back(CH_SPACE);
				end
			endcase
			foreach (txt[i]) begin
				w.ch = txt[i];
				w.fin = (i == txt.size() - 1);
				awaited.push_back(w);
			end
		endfunction

		function void check_char(logic [7:0] ch, logic fin);
			char_word_t w;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: char_out=%h last=%b", ch, fin);
				return;
			end
			w = awaited.pop_front();
			if (ch !== w.ch || fin !== w.fin) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: char_out=%h last=%b, expected char_out=%h last=%b",
						ch, fin, w.ch, w.fin);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  mode = MODE_PCT;
	logic [31:0] value = '0;
	logic [5:0]  field_width = '0;
	logic        zero_fill = 1'b0;
	logic        left_justify = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  char_out;
	logic        last;

	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	conversion_checker fmt_check = new();

	integer_field_formatter u_top (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side: take words and pick the next ready level
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				fmt_check.check_char(char_out, last);
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send_request(logic [2:0] md, logic [31:0] val, logic [5:0] fw,
		logic zp, logic lj);
		int gap;
		gap = 0;
		while (gap < 30 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		value <= val;
		field_width <= fw;
		zero_fill <= zp;
		left_justify <= lj;
		do @(posedge clk); while (!in_ready);
		fmt_check.note_request(md, val, fw, zp, lj);
	endtask

	// hold the input side until every pending character is out
	task automatic drain_outputs();
		in_valid <= 1'b0;
		while (fmt_check.awaited.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random();
		logic [2:0] md;
		logic [31:0] val;
		logic [5:0] fw;
		int r;
		r = $urandom_range(99);
		if (r < 70)
			md = 3'($urandom_range(3));
		else if (r < 80)
			md = MODE_PTR;
		else if (r < 88)
			md = MODE_CHAR;
		else if (r < 96)
			md = MODE_PCT;
		else
			md = MODE_PCT_ALT;
		case ($urandom_range(9))
			0, 1, 2, 3: val = $urandom;
			4, 5: val = $urandom_range(999);
			6: begin
				case ($urandom_range(3))
					0: val = 32'h8000_0000;
					1: val = 32'h7FFF_FFFF;
					2: val = 32'hFFFF_FFFF;
					default: val = 32'h0;
				endcase
			end
			7: val = 32'd0 - 32'($urandom_range(999, 1));
			8: val = 32'd1 << $urandom_range(31);
			default: val = $urandom >> $urandom_range(31);
		endcase
		fw = ($urandom_range(99) < 85) ? 6'($urandom_range(12)) : 6'($urandom_range(63));
		send_request(md, val, fw, 1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(MODE_SDEC, 32'h0, 6'd0, 1'b0, 1'b0);
		send_request(MODE_SDEC, 32'h8000_0000, 6'd0, 1'b0, 1'b0);
		send_request(MODE_SDEC, 32'h8000_0000, 6'd12, 1'b1, 1'b0);
		send_request(MODE_SDEC, 32'hFFFF_FFFF, 6'd5, 1'b0, 1'b1);
		send_request(MODE_SDEC, 32'h7FFF_FFFF, 6'd0, 1'b0, 1'b0);
		send_request(MODE_SDEC, -32'sd42, 6'd8, 1'b1, 1'b0);
		// left wins over zero padding
		send_request(MODE_SDEC, -32'sd42, 6'd8, 1'b1, 1'b1);
		send_request(MODE_SDEC, 32'd123, 6'd63, 1'b0, 1'b0);
		send_request(MODE_SDEC, 32'h8000_0000, 6'd63, 1'b0, 1'b1);
		send_request(MODE_UDEC, 32'hFFFF_FFFF, 6'd0, 1'b0, 1'b0);
		send_request(MODE_UDEC, 32'd7, 6'd3, 1'b1, 1'b0);
		send_request(MODE_UDEC, 32'd0, 6'd63, 1'b1, 1'b0);
		send_request(MODE_HEXL, 32'hDEAD_BEEF, 6'd10, 1'b0, 1'b0);
		send_request(MODE_HEXU, 32'hDEAD_BEEF, 6'd10, 1'b1, 1'b0);
		send_request(MODE_HEXL, 32'h0, 6'd1, 1'b0, 1'b0);
		send_request(MODE_HEXU, 32'h00AB_CDEF, 6'd9, 1'b0, 1'b1);
		send_request(MODE_PTR, 32'h0, 6'd20, 1'b1, 1'b0);
		send_request(MODE_PTR, 32'hFFFF_FFFF, 6'd40, 1'b0, 1'b1);
		send_request(MODE_CHAR, 32'h41, 6'd0, 1'b0, 1'b0);
		send_request(MODE_CHAR, 32'h0, 6'd5, 1'b1, 1'b0);
		send_request(MODE_CHAR, 32'hFFFF_FF7E, 6'd30, 1'b0, 1'b1);
		send_request(MODE_PCT, 32'hFFFF_FFFF, 6'd10, 1'b1, 1'b1);
		send_request(MODE_PCT_ALT, 32'h1234_5678, 6'd63, 1'b0, 1'b0);
		drain_outputs();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case (i)
				0: begin idle_pct = 0; stall_pct = 0; end
				32: begin idle_pct = 66; stall_pct = 0; end
				64: begin idle_pct = 0; stall_pct = 66; end
				96: begin idle_pct = 19; stall_pct = 19; end
				default: ;
			endcase
			if (i == 80)
				drain_outputs();
			send_random();
		end
		in_valid <= 1'b0;

		while (fmt_check.awaited.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fmt_check.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
